@@ rtl/fprs_pkg.sv @@
// Shared constants and the sine table generator for the phase ramp shift unit.
package fprs_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_STEP = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_STEP = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Z_STEP = 2'd2;

   // Quadrant codes taken from the top two bits of the phase.
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   // Trig values are Q1.15: a 15-bit magnitude plus sign.
   localparam int unsigned TRIG_FRAC = 15;
   localparam int unsigned TRIG_W    = 16;
   localparam int unsigned MAG_W     = 15;
   localparam int          ROUND_BIAS = 16384;

   // Phase is aligned to 32 bits before the quadrant and address are taken.
   localparam int unsigned PHASE_ALIGN_W = 32;

   // Number of register stages from input acceptance to the output register.
   localparam int unsigned PIPE_DEPTH = 7;
   localparam int unsigned INFLIGHT_W = 4;

   // Taylor series constants for the table generator (Q30 arithmetic).
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210, 64'd272};

   // Table entry k of a quarter wave with 2^addr_bits steps: sin(pi/2*k/N) in Q1.15,
   // rounded half up and capped at full scale. Evaluated at elaboration only.
   function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned addr_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned q;
      longint          acc;
      x    = (HALF_PI_Q30 * longint'(k)) >> addr_bits;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
         if ((n % 2) == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      q = ((longint'(acc) * 64'd32768) + (64'd1 << 29)) >> 30;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[MAG_W-1:0];
   endfunction

endpackage

@@ rtl/fprs_ifs.sv @@
// Channel interfaces of the phase ramp shift unit: element input, result output, register writes.
interface fprs_req_if #(
   parameter int unsigned INDEX_BITS   = 10,
   parameter int unsigned SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic        [INDEX_BITS-1:0]   col;
   logic        [INDEX_BITS-1:0]   row;
   logic        [INDEX_BITS-1:0]   slice;
   logic signed [SAMPLE_WIDTH-1:0] re_in;
   logic signed [SAMPLE_WIDTH-1:0] im_in;

   modport source (output valid, col, row, slice, re_in, im_in, input ready);
   modport sink   (input valid, col, row, slice, re_in, im_in, output ready);
endinterface

interface fprs_rsp_if #(
   parameter int unsigned SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] re_out;
   logic signed [SAMPLE_WIDTH-1:0] im_out;

   modport source (output valid, re_out, im_out, input ready);
   modport sink   (input valid, re_out, im_out, output ready);
endinterface

interface fprs_csr_if #(
   parameter int unsigned PHASE_BITS = 24
);
   logic                                  valid;
   logic                                  ready;
   logic [fprs_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [PHASE_BITS-1:0]                 data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/fprs_phase.sv @@
// Phase accumulation: three index-by-step products, then the wrapped sum split into quadrant and table address.
module fprs_phase #(
   parameter int unsigned INDEX_BITS      = 10,
   parameter int unsigned SAMPLE_WIDTH    = 16,
   parameter int unsigned PHASE_BITS      = 24,
   parameter int unsigned TABLE_ADDR_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic        [PHASE_BITS-1:0]      x_step,
   input  logic        [PHASE_BITS-1:0]      y_step,
   input  logic        [PHASE_BITS-1:0]      z_step,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic        [INDEX_BITS-1:0]      col,
   input  logic        [INDEX_BITS-1:0]      row,
   input  logic        [INDEX_BITS-1:0]      slice,
   input  logic signed [SAMPLE_WIDTH-1:0]    re_in,
   input  logic signed [SAMPLE_WIDTH-1:0]    im_in,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic        [1:0]                 out_quad,
   output logic        [TABLE_ADDR_BITS-1:0] out_addr,
   output logic signed [SAMPLE_WIDTH-1:0]    out_re,
   output logic signed [SAMPLE_WIDTH-1:0]    out_im
);

   localparam int unsigned PROD_W = INDEX_BITS + PHASE_BITS;
   localparam int unsigned PAD    = fprs_pkg::PHASE_ALIGN_W - PHASE_BITS;

   logic                           en1;
   logic                           en2;
   logic                           v1_ff;
   logic                           v2_ff;
   logic        [PROD_W-1:0]       mul_x_in;
   logic        [PROD_W-1:0]       mul_y_in;
   logic        [PROD_W-1:0]       mul_z_in;
   logic        [PHASE_BITS-1:0]   prod_x_ff;
   logic        [PHASE_BITS-1:0]   prod_y_ff;
   logic        [PHASE_BITS-1:0]   prod_z_ff;
   logic signed [SAMPLE_WIDTH-1:0] re1_ff;
   logic signed [SAMPLE_WIDTH-1:0] im1_ff;
   logic        [PHASE_BITS-1:0]   phase_in;
   logic [fprs_pkg::PHASE_ALIGN_W-1:0] aligned;
   logic        [1:0]                 quad_ff;
   logic        [TABLE_ADDR_BITS-1:0] addr_ff;
   logic signed [SAMPLE_WIDTH-1:0]    re2_ff;
   logic signed [SAMPLE_WIDTH-1:0]    im2_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign mul_x_in = PROD_W'(col)   * PROD_W'(x_step);
   assign mul_y_in = PROD_W'(row)   * PROD_W'(y_step);
   assign mul_z_in = PROD_W'(slice) * PROD_W'(z_step);

   // The sum wraps at one full turn by keeping only PHASE_BITS bits.
   assign phase_in = prod_x_ff + prod_y_ff + prod_z_ff;
   assign aligned  = fprs_pkg::PHASE_ALIGN_W'(phase_in) << PAD;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         prod_x_ff <= mul_x_in[PHASE_BITS-1:0];
         prod_y_ff <= mul_y_in[PHASE_BITS-1:0];
         prod_z_ff <= mul_z_in[PHASE_BITS-1:0];
         re1_ff    <= re_in;
         im1_ff    <= im_in;
      end
      if (en2 && v1_ff) begin
         quad_ff <= aligned[fprs_pkg::PHASE_ALIGN_W-1 -: 2];
         addr_ff <= aligned[fprs_pkg::PHASE_ALIGN_W-3 -: TABLE_ADDR_BITS];
         re2_ff  <= re1_ff;
         im2_ff  <= im1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_quad  = quad_ff;
   assign out_addr  = addr_ff;
   assign out_re    = re2_ff;
   assign out_im    = im2_ff;

endmodule

@@ rtl/fprs_sincos.sv @@
// Quarter-wave sine ROM with two registered read ports and the quadrant sign fold.
module fprs_sincos #(
   parameter int unsigned SAMPLE_WIDTH    = 16,
   parameter int unsigned TABLE_ADDR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic        [1:0]                   quad,
   input  logic        [TABLE_ADDR_BITS-1:0]   addr,
   input  logic signed [SAMPLE_WIDTH-1:0]      re_in,
   input  logic signed [SAMPLE_WIDTH-1:0]      im_in,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [fprs_pkg::TRIG_W-1:0]  out_cos,
   output logic signed [fprs_pkg::TRIG_W-1:0]  out_sin,
   output logic signed [SAMPLE_WIDTH-1:0]      out_re,
   output logic signed [SAMPLE_WIDTH-1:0]      out_im
);

   localparam int unsigned TBL_N  = 1 << TABLE_ADDR_BITS;
   localparam int unsigned ROM_AW = TABLE_ADDR_BITS + 1;

   typedef logic [fprs_pkg::MAG_W-1:0] rom_type [TBL_N+1];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int unsigned k = 0; k <= TBL_N; k++) begin
         rom[k] = fprs_pkg::sine_entry(k, TABLE_ADDR_BITS);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic                               en1;
   logic                               en2;
   logic                               v1_ff;
   logic                               v2_ff;
   logic [ROM_AW-1:0]                  sin_addr;
   logic [ROM_AW-1:0]                  cos_addr;
   logic [fprs_pkg::MAG_W-1:0]         sin_mag_ff;
   logic [fprs_pkg::MAG_W-1:0]         cos_mag_ff;
   logic [1:0]                         quad_ff;
   logic signed [SAMPLE_WIDTH-1:0]     re1_ff;
   logic signed [SAMPLE_WIDTH-1:0]     im1_ff;
   logic signed [fprs_pkg::TRIG_W-1:0] s_pos;
   logic signed [fprs_pkg::TRIG_W-1:0] c_pos;
   logic signed [fprs_pkg::TRIG_W-1:0] sin_in;
   logic signed [fprs_pkg::TRIG_W-1:0] cos_in;
   logic signed [fprs_pkg::TRIG_W-1:0] sin_ff;
   logic signed [fprs_pkg::TRIG_W-1:0] cos_ff;
   logic signed [SAMPLE_WIDTH-1:0]     re2_ff;
   logic signed [SAMPLE_WIDTH-1:0]     im2_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Cosine is read as the sine of the complementary angle.
   assign sin_addr = ROM_AW'(addr);
   assign cos_addr = ROM_AW'(TBL_N) - ROM_AW'(addr);

   assign s_pos = signed'({1'b0, sin_mag_ff});
   assign c_pos = signed'({1'b0, cos_mag_ff});

   always_comb begin
      case (quad_ff)
         fprs_pkg::QUAD_FIRST: begin
            sin_in = s_pos;
            cos_in = c_pos;
         end
         fprs_pkg::QUAD_SECOND: begin
            sin_in = c_pos;
            cos_in = -s_pos;
         end
         fprs_pkg::QUAD_THIRD: begin
            sin_in = -s_pos;
            cos_in = -c_pos;
         end
         default: begin
            sin_in = -c_pos;
            cos_in = s_pos;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         sin_mag_ff <= SINE_ROM[sin_addr];
         cos_mag_ff <= SINE_ROM[cos_addr];
         quad_ff    <= quad;
         re1_ff     <= re_in;
         im1_ff     <= im_in;
      end
      if (en2 && v1_ff) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
         re2_ff <= re1_ff;
         im2_ff <= im1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_re    = re2_ff;
   assign out_im    = im2_ff;

endmodule

@@ rtl/fprs_rotate.sv @@
// Complex rotation: four products, rounded sums, saturation into the output register.
module fprs_rotate #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [fprs_pkg::TRIG_W-1:0] cos_in,
   input  logic signed [fprs_pkg::TRIG_W-1:0] sin_in,
   input  logic signed [SAMPLE_WIDTH-1:0]     re_in,
   input  logic signed [SAMPLE_WIDTH-1:0]     im_in,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [SAMPLE_WIDTH-1:0]     re_out,
   output logic signed [SAMPLE_WIDTH-1:0]     im_out
);

   localparam int unsigned PROD_W = SAMPLE_WIDTH + fprs_pkg::TRIG_W;
   localparam int unsigned ACC_W  = PROD_W + 1;
   localparam int unsigned RND_W  = ACC_W - fprs_pkg::TRIG_FRAC;

   logic                           en1;
   logic                           en2;
   logic                           en3;
   logic                           v1_ff;
   logic                           v2_ff;
   logic                           v3_ff;
   logic signed [PROD_W-1:0]       p_rc_in;
   logic signed [PROD_W-1:0]       p_is_in;
   logic signed [PROD_W-1:0]       p_ic_in;
   logic signed [PROD_W-1:0]       p_rs_in;
   logic signed [PROD_W-1:0]       p_rc_ff;
   logic signed [PROD_W-1:0]       p_is_ff;
   logic signed [PROD_W-1:0]       p_ic_ff;
   logic signed [PROD_W-1:0]       p_rs_ff;
   logic signed [ACC_W-1:0]        sum_re_in;
   logic signed [ACC_W-1:0]        sum_im_in;
   logic signed [RND_W-1:0]        rnd_re_ff;
   logic signed [RND_W-1:0]        rnd_im_ff;
   logic signed [SAMPLE_WIDTH-1:0] sat_re_in;
   logic signed [SAMPLE_WIDTH-1:0] sat_im_in;
   logic signed [SAMPLE_WIDTH-1:0] re_out_ff;
   logic signed [SAMPLE_WIDTH-1:0] im_out_ff;

   // Clamp a rounded value to the sample range; it fits when its top bits agree.
   function automatic logic signed [SAMPLE_WIDTH-1:0] saturate(
      input logic signed [RND_W-1:0] v
   );
      logic [RND_W-SAMPLE_WIDTH:0] top;
      top = v[RND_W-1:SAMPLE_WIDTH-1];
      if ((top == '0) || (top == '1)) begin
         return v[SAMPLE_WIDTH-1:0];
      end else if (v[RND_W-1]) begin
         return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   endfunction

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign p_rc_in = re_in * cos_in;
   assign p_is_in = im_in * sin_in;
   assign p_ic_in = im_in * cos_in;
   assign p_rs_in = re_in * sin_in;

   assign sum_re_in = ACC_W'(p_rc_ff) + ACC_W'(p_is_ff) + ACC_W'(fprs_pkg::ROUND_BIAS);
   assign sum_im_in = ACC_W'(p_ic_ff) - ACC_W'(p_rs_ff) + ACC_W'(fprs_pkg::ROUND_BIAS);

   assign sat_re_in = saturate(rnd_re_ff);
   assign sat_im_in = saturate(rnd_im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         p_rc_ff <= p_rc_in;
         p_is_ff <= p_is_in;
         p_ic_ff <= p_ic_in;
         p_rs_ff <= p_rs_in;
      end
      if (en2 && v1_ff) begin
         // Dropping the fraction bits floors the biased sum: round half up.
         rnd_re_ff <= sum_re_in[ACC_W-1 -: RND_W];
         rnd_im_ff <= sum_im_in[ACC_W-1 -: RND_W];
      end
      if (en3 && v2_ff) begin
         re_out_ff <= sat_re_in;
         im_out_ff <= sat_im_in;
      end
   end

   assign out_valid = v3_ff;
   assign re_out    = re_out_ff;
   assign im_out    = im_out_ff;

endmodule

@@ rtl/fourier_phase_ramp_shift_unit.sv @@
// Top level of the Fourier phase ramp shift unit: step registers, the pipeline, and its checks.
//
// This unit multiplies one complex spectrum element per item by exp(-i*2*pi*phase), where the
// phase in turns is col*x_step + row*y_step + slice*z_step modulo one turn, which shifts the
// image by the amounts the three steps encode. Software writes each step as an unsigned
// PHASE_BITS-bit fraction of a turn (shift divided by axis size) through the register port:
// index 0 is x_step, 1 is y_step, 2 is z_step; other indexes are ignored, and writes are always
// accepted. Steps of axes that are not used are left at zero. Write the steps only while no item
// is in flight. The unit takes one item per clock cycle when the output is not stalled and holds
// no state between items. Each item passes through seven register stages: three index products,
// the wrapped phase sum split into quadrant and table address, the sine ROM read, the quadrant
// sign fold, four sample-by-trig products, the rounded sums, and the saturating output register.
// The sine and cosine come from one quarter-wave table of 2^TABLE_ADDR_BITS+1 Q1.15 entries read
// at two addresses per cycle; phase bits below the table address are dropped, with no
// interpolation. Results are rounded half up and saturated to SAMPLE_WIDTH bits. Every stage
// has its own valid bit, so a stalled output only holds the stages behind it until a bubble is
// found, and an item is still accepted while a finished result waits to be taken as long as
// some stage behind it is empty.
module fourier_phase_ramp_shift_unit #(
   parameter int unsigned INDEX_BITS      = 10,
   parameter int unsigned SAMPLE_WIDTH    = 16,
   parameter int unsigned PHASE_BITS      = 24,
   parameter int unsigned TABLE_ADDR_BITS = 10
) (
   input logic     clock,
   input logic     reset,
   fprs_req_if.sink   req_ch,
   fprs_rsp_if.source rsp_ch,
   fprs_csr_if.sink   csr_ch
);

   // Step registers, cleared by reset.
   logic [PHASE_BITS-1:0] x_step_ff;
   logic [PHASE_BITS-1:0] y_step_ff;
   logic [PHASE_BITS-1:0] z_step_ff;

   // Phase stage to table stage.
   logic                           ph_valid;
   logic                           ph_ready;
   logic        [1:0]              ph_quad;
   logic [TABLE_ADDR_BITS-1:0]     ph_addr;
   logic signed [SAMPLE_WIDTH-1:0] ph_re;
   logic signed [SAMPLE_WIDTH-1:0] ph_im;

   // Table stage to rotation stage.
   logic                               tr_valid;
   logic                               tr_ready;
   logic signed [fprs_pkg::TRIG_W-1:0] tr_cos;
   logic signed [fprs_pkg::TRIG_W-1:0] tr_sin;
   logic signed [SAMPLE_WIDTH-1:0]     tr_re;
   logic signed [SAMPLE_WIDTH-1:0]     tr_im;

   // Count of items accepted but not yet delivered, kept for the checks below.
   logic                               item_in;
   logic                               item_out;
   logic [fprs_pkg::INFLIGHT_W-1:0]    inflight_ff;
   logic [fprs_pkg::INFLIGHT_W-1:0]    inflight_in;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_step_ff <= '0;
         y_step_ff <= '0;
         z_step_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            fprs_pkg::CSR_X_STEP: x_step_ff <= csr_ch.data;
            fprs_pkg::CSR_Y_STEP: y_step_ff <= csr_ch.data;
            fprs_pkg::CSR_Z_STEP: z_step_ff <= csr_ch.data;
            default: begin
               // Indexes past the register list are ignored.
            end
         endcase
      end
   end

   fprs_phase #(
      .INDEX_BITS      (INDEX_BITS),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .x_step    (x_step_ff),
      .y_step    (y_step_ff),
      .z_step    (z_step_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .col       (req_ch.col),
      .row       (req_ch.row),
      .slice     (req_ch.slice),
      .re_in     (req_ch.re_in),
      .im_in     (req_ch.im_in),
      .out_valid (ph_valid),
      .out_ready (ph_ready),
      .out_quad  (ph_quad),
      .out_addr  (ph_addr),
      .out_re    (ph_re),
      .out_im    (ph_im)
   );

   fprs_sincos #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_sincos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ph_valid),
      .in_ready  (ph_ready),
      .quad      (ph_quad),
      .addr      (ph_addr),
      .re_in     (ph_re),
      .im_in     (ph_im),
      .out_valid (tr_valid),
      .out_ready (tr_ready),
      .out_cos   (tr_cos),
      .out_sin   (tr_sin),
      .out_re    (tr_re),
      .out_im    (tr_im)
   );

   fprs_rotate #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tr_valid),
      .in_ready  (tr_ready),
      .cos_in    (tr_cos),
      .sin_in    (tr_sin),
      .re_in     (tr_re),
      .im_in     (tr_im),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .re_out    (rsp_ch.re_out),
      .im_out    (rsp_ch.im_out)
   );

   assign item_in     = req_ch.valid && req_ch.ready;
   assign item_out    = rsp_ch.valid && rsp_ch.ready;
   assign inflight_in = inflight_ff + fprs_pkg::INFLIGHT_W'(item_in)
                        - fprs_pkg::INFLIGHT_W'(item_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // The pipeline can never hold more items than it has stages.
   a_inflight_bounded: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= fprs_pkg::INFLIGHT_W'(fprs_pkg::PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

   // A result is only offered for an item that was accepted and not yet delivered.
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (inflight_ff != '0))
      else $error("result offered with no item in flight");

   // With the output register empty every stage can move, so the input must be ready.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid |-> req_ch.ready)
      else $error("input stalled although the output register is empty");

   // A write to the slice step lands in its register on the next cycle.
   a_z_step_written: assert property (@(posedge clock) disable iff (reset)
      (csr_ch.valid && csr_ch.ready && (csr_ch.index == fprs_pkg::CSR_Z_STEP))
      |=> (z_step_ff == $past(csr_ch.data)))
      else $error("slice step register did not take the written value");

endmodule

@@ sim/tb_fourier_phase_ramp_shift_unit.sv @@
// Self-checking testbench for the phase ramp shift unit: directed plan, then random traffic.
module tb_fourier_phase_ramp_shift_unit;

   localparam int unsigned INDEX_BITS      = 10;
   localparam int unsigned SAMPLE_WIDTH    = 16;
   localparam int unsigned PHASE_BITS      = 24;
   localparam int unsigned TABLE_ADDR_BITS = 10;
   localparam int unsigned TABLE_POINTS    = 1 << TABLE_ADDR_BITS;

   // Register index that decodes to nothing; writes to it must leave every step alone.
   localparam logic [fprs_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   // pi/2 in Q30, the argument scale of the quarter-wave series.
   localparam longint unsigned QUARTER_TURN_RAD_Q30 = 64'd1686629713;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   localparam int unsigned ITEMS_PER_PHASE = 150;
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned MAX_PRINTED     = 60;

   typedef logic        [INDEX_BITS-1:0]   index_type;
   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic        [PHASE_BITS-1:0]   step_type;

   typedef struct {
      index_type  col;
      index_type  row;
      index_type  slice;
      sample_type re;
      sample_type im;
   } element_type;

   typedef struct {
      sample_type re;
      sample_type im;
   } sample_pair_type;

   typedef enum bit {ROW_ELEMENT, ROW_WRITE} row_kind_type;

   // One row of the directed plan: either a register write or an element. Rows whose result
   // is obvious carry it typed in; the rest are checked against the predictor.
   // Field order: kind, register index, register value, col, row, slice, re, im, typed,
   // wanted re, wanted im.
   typedef struct {
      row_kind_type                        kind;
      logic [fprs_pkg::CSR_INDEX_BITS-1:0] reg_index;
      step_type                            reg_value;
      index_type                           col;
      index_type                           row;
      index_type                           slice;
      sample_type                          re;
      sample_type                          im;
      bit                                  typed;
      sample_type                          re_want;
      sample_type                          im_want;
   } plan_row_type;

   localparam int unsigned PLAN_ROWS = 26;

   // After reset every step is zero, so the rotation is by cos = full scale, sin = 0 and the
   // output is the input scaled by 32767/32768. With x at an eighth of a turn, cos = sin and the
   // imaginary output cancels exactly while the real output saturates.
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 0, 0, 0, 0, 0, 1, 0, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 1023, 1023, 1023, 32767, 0, 1, 32766, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 1023, 0, 512, -32768, 0, 1, -32767, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 0, 1023, 0, 0, -32768, 1, 0, -32767},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 512, 256, 128, 32767, 32767, 1, 32766,
        32766},
      '{ROW_WRITE,   fprs_pkg::CSR_X_STEP, 24'h200000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE,   fprs_pkg::CSR_Y_STEP, 24'h400000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE,   fprs_pkg::CSR_Z_STEP, 24'h800000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 1, 0, 0, -32768, -32768, 1, -32768, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 1, 0, 0, 32767, 32767, 1, 32767, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 0, 1, 0, 12345, -321, 0, 0, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 0, 0, 1, -32768, 32767, 0, 0, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 3, 1, 1, 1000, -1000, 0, 0, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 6, 0, 0, 32767, -32768, 0, 0, 0},
      '{ROW_WRITE,   fprs_pkg::CSR_X_STEP, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE,   fprs_pkg::CSR_Y_STEP, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE,   fprs_pkg::CSR_Z_STEP, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 1023, 1023, 1023, -32768, -32768, 0, 0,
        0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 1, 0, 0, 20000, -20000, 0, 0, 0},
      '{ROW_WRITE,   CSR_SPARE,            24'h123456, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 1023, 1, 0, -777, 4321, 0, 0, 0},
      '{ROW_WRITE,   fprs_pkg::CSR_X_STEP, 24'h000001, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE,   fprs_pkg::CSR_Y_STEP, 24'h000000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE,   fprs_pkg::CSR_Z_STEP, 24'h000000, 0, 0, 0, 0, 0, 0, 0, 0},
      // Phase 1023 lies below the first table step, so this is still the zero rotation.
      '{ROW_ELEMENT, fprs_pkg::CSR_X_STEP, 24'h000000, 1023, 0, 0, 32767, 0, 1, 32766, 0},
      // A step of exactly one table point, then the largest column.
      '{ROW_WRITE,   fprs_pkg::CSR_X_STEP, 24'h001000, 0, 0, 0, 0, 0, 0, 0, 0}
   };

   // Idle and stall percentages of the four random phases.
   int unsigned idle_plan  [4] = '{0, 70, 0, 26};
   int unsigned stall_plan [4] = '{0, 0, 70, 26};

   logic clock;
   logic reset;

   fprs_req_if #(.INDEX_BITS(INDEX_BITS), .SAMPLE_WIDTH(SAMPLE_WIDTH)) req_ch ();
   fprs_rsp_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH))                         rsp_ch ();
   fprs_csr_if #(.PHASE_BITS(PHASE_BITS))                             csr_ch ();

   fourier_phase_ramp_shift_unit #(
      .INDEX_BITS      (INDEX_BITS),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor state: the three steps as last written and the quarter-wave sine table.
   step_type        axis_step [3];
   int              sine_q15 [TABLE_POINTS + 1];
   sample_pair_type rotations_due [$];
   sample_pair_type oldest_due;

   int unsigned receiver_stall_pct;
   int unsigned cycle_count;
   int unsigned mismatches;
   int unsigned elements_sent;
   int unsigned results_checked;
   int unsigned register_writes;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Quarter-wave sine in Q1.15, from a nine-term Taylor series in Q30 where every term is
   // truncated after its multiply and its divide; the final value is rounded half up and
   // capped at full scale.
   function automatic void fill_quarter_wave();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned q;
      longint          acc;
      for (int k = 0; k <= TABLE_POINTS; k++) begin
         x    = (QUARTER_TURN_RAD_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         q = (64'(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         sine_q15[k] = int'(q);
      end
   endfunction

   // Rounds a Q15-scaled sum half up (floor after adding half) and clamps it to the sample range.
   function automatic sample_type round_saturate(input longint acc);
      longint r;
      r = (acc + longint'(fprs_pkg::ROUND_BIAS)) >>> fprs_pkg::TRIG_FRAC;
      if (r > SAMPLE_MAX) begin
         r = SAMPLE_MAX;
      end
      if (r < SAMPLE_MIN) begin
         r = SAMPLE_MIN;
      end
      return sample_type'(r);
   endfunction

   // Expected output for one element: the phase wraps modulo one turn, the top two bits choose
   // the quadrant and the next bits address the table; the rest of the phase is dropped.
   function automatic sample_pair_type rotate_element(input element_type e);
      longint unsigned turns;
      step_type        phase;
      logic [1:0]      quad;
      int unsigned     addr;
      longint          sn;
      longint          cs;
      longint          re;
      longint          im;
      sample_pair_type out;
      turns = 64'(e.col) * 64'(axis_step[0]) + 64'(e.row) * 64'(axis_step[1])
            + 64'(e.slice) * 64'(axis_step[2]);
      phase = turns[PHASE_BITS-1:0];
      quad  = phase[PHASE_BITS-1 -: 2];
      addr  = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      case (quad)
         fprs_pkg::QUAD_FIRST: begin
            sn = sine_q15[addr];
            cs = sine_q15[TABLE_POINTS - addr];
         end
         fprs_pkg::QUAD_SECOND: begin
            sn = sine_q15[TABLE_POINTS - addr];
            cs = -sine_q15[addr];
         end
         fprs_pkg::QUAD_THIRD: begin
            sn = -sine_q15[addr];
            cs = -sine_q15[TABLE_POINTS - addr];
         end
         default: begin
            sn = -sine_q15[TABLE_POINTS - addr];
            cs = sine_q15[addr];
         end
      endcase
      re     = e.re;
      im     = e.im;
      out.re = round_saturate(re * cs + im * sn);
      out.im = round_saturate(im * cs - re * sn);
      return out;
   endfunction

   function automatic index_type random_index();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return index_type'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(7))
         0:       return {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
         1:       return {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Steps favor zero (unused axis), full scale and exact table points, besides free values.
   function automatic step_type random_step();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return step_type'($urandom_range(TABLE_POINTS * 4 - 1))
                         << (PHASE_BITS - TABLE_ADDR_BITS - 2);
         default: return step_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_PRINTED) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
      mismatches++;
   endtask

   // Offers one element at a falling edge, after a random number of idle cycles, and records
   // its expected result at the rising edge that accepts it. Valid is left high afterwards so
   // that the next element can follow without a bubble.
   task automatic offer_element(input element_type e, input sample_pair_type want,
                                input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.col   = e.col;
      req_ch.row   = e.row;
      req_ch.slice = e.slice;
      req_ch.re_in = e.re;
      req_ch.im_in = e.im;
      do @(posedge clock); while (!req_ch.ready);
      rotations_due.push_back(want);
      elements_sent++;
      @(negedge clock);
   endtask

   // Holds the element channel quiet until every accepted element has produced its result.
   task automatic drain_pipeline();
      req_ch.valid = 1'b0;
      while (rotations_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Writes one register through its channel; the predictor copies the value only for the three
   // step registers, since any other index is ignored by the block.
   task automatic write_register(input logic [fprs_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input step_type value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx) inside
         fprs_pkg::CSR_X_STEP, fprs_pkg::CSR_Y_STEP, fprs_pkg::CSR_Z_STEP:
            axis_step[idx] = value;
         default: ;
      endcase
      register_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // The receiver stalls at random, decided at each falling edge.
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
   end

   // Every accepted result is checked against the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rotations_due.size() == 0) begin
            report_mismatch($sformatf("result re=%0d im=%0d with nothing outstanding",
                                      rsp_ch.re_out, rsp_ch.im_out));
         end else begin
            oldest_due = rotations_due.pop_front();
            results_checked++;
            if (rsp_ch.re_out !== oldest_due.re) begin
               report_mismatch($sformatf("result %0d re_out %0d, wanted %0d",
                                         results_checked, rsp_ch.re_out, oldest_due.re));
            end
            if (rsp_ch.im_out !== oldest_due.im) begin
               report_mismatch($sformatf("result %0d im_out %0d, wanted %0d",
                                         results_checked, rsp_ch.im_out, oldest_due.im));
            end
         end
      end
   end

   // A run that stops making progress is cut off here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      element_type     e;
      sample_pair_type want;
      logic [fprs_pkg::CSR_INDEX_BITS-1:0] step_regs [3];

      step_regs = '{fprs_pkg::CSR_X_STEP, fprs_pkg::CSR_Y_STEP, fprs_pkg::CSR_Z_STEP};

      // Every input but the receiver's ready is known from time zero, and reset is held high at
      // first and dropped at a falling edge.
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.col         = '0;
      req_ch.row         = '0;
      req_ch.slice       = '0;
      req_ch.re_in       = '0;
      req_ch.im_in       = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = fprs_pkg::CSR_X_STEP;
      csr_ch.data        = '0;
      receiver_stall_pct = 0;
      elements_sent      = 0;
      register_writes    = 0;
      axis_step          = '{'0, '0, '0};
      fill_quarter_wave();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed plan: extremes, every quadrant, saturation, table points, ignored writes.
      // Register rows wait for the pipeline to empty, since the steps may only change while
      // nothing is in flight.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            drain_pipeline();
            write_register(directed_plan[i].reg_index, directed_plan[i].reg_value);
         end else begin
            e.col   = directed_plan[i].col;
            e.row   = directed_plan[i].row;
            e.slice = directed_plan[i].slice;
            e.re    = directed_plan[i].re;
            e.im    = directed_plan[i].im;
            if (directed_plan[i].typed) begin
               want.re = directed_plan[i].re_want;
               want.im = directed_plan[i].im_want;
            end else begin
               want = rotate_element(e);
            end
            offer_element(e, want, 0);
         end
      end

      // The last directed write set x to one table point; probe it at column 1 and the largest column.
      e = '{1, 0, 0, 32767, -32768};
      offer_element(e, rotate_element(e), 0);
      e = '{1023, 0, 0, -32768, 32767};
      offer_element(e, rotate_element(e), 0);

      // Random phases: new steps while idle, then a stream of elements under the phase's idle
      // and stall pattern. Halfway through the sender-idle phase the sender also waits for the
      // pipeline to run completely dry before carrying on.
      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         drain_pipeline();
         receiver_stall_pct = stall_plan[phase_no];
         foreach (step_regs[r]) begin
            write_register(step_regs[r], random_step());
         end
         if ($urandom_range(2) == 0) begin
            write_register(CSR_SPARE, random_step());
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase_no == 1 && n == ITEMS_PER_PHASE / 2) begin
               drain_pipeline();
            end
            e.col   = random_index();
            e.row   = random_index();
            e.slice = random_index();
            e.re    = random_sample();
            e.im    = random_sample();
            offer_element(e, rotate_element(e), idle_plan[phase_no]);
         end
      end

      // Let stray results show up after the last expected one has been taken.
      drain_pipeline();
      receiver_stall_pct = 0;
      repeat (4 * fprs_pkg::PIPE_DEPTH) @(negedge clock);

      $display("run covered %0d elements and %0d results over %0d register writes,",
               elements_sent, results_checked, register_writes);
      $display("with sender gaps and receiver stalls mixed across four phases");
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/fprs_pkg.sv
rtl/fprs_ifs.sv
rtl/fprs_phase.sv
rtl/fprs_sincos.sv
rtl/fprs_rotate.sv
rtl/fourier_phase_ramp_shift_unit.sv
sim/tb_fourier_phase_ramp_shift_unit.sv
